// ===== src/spk_pkg.sv =====
// Shared types, constants and round functions for the Speck 64/128 core.
`timescale 1ns / 1ps

package spk_pkg;

    localparam int WORD_W  = 32;
    localparam int ROUNDS  = 27;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [WORD_W-1:0] KEY0_RESET = 32'h0302_0100;
    localparam logic [WORD_W-1:0] KEY1_RESET = 32'h0b0a_0908;
    localparam logic [WORD_W-1:0] KEY2_RESET = 32'h1312_1110;
    localparam logic [WORD_W-1:0] KEY3_RESET = 32'h1b1a_1918;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'h0000_0000;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0 = 3'd0,
        CFG_KEY1 = 3'd1,
        CFG_KEY2 = 3'd2,
        CFG_KEY3 = 3'd3,
        CFG_SEED = 3'd4
    } cfg_idx_e;

    // One cipher block: y is word zero, x is word one.
    typedef struct packed {
        word_t x;
        word_t y;
    } blk_t;

    typedef struct packed {
        word_t k3;
        word_t k2;
        word_t k1;
        word_t k0;
    } key_t;

    function automatic word_t ror8(input word_t v);
        return {v[7:0], v[WORD_W-1:8]};
    endfunction

    function automatic word_t rol3(input word_t v);
        return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
    endfunction

    // One Speck round on (x, y) with round key k.
    function automatic blk_t round_mix(input blk_t b, input word_t k);
        blk_t r;
        r.x = (ror8(b.x) + b.y) ^ k;
        r.y = rol3(b.y) ^ r.x;
        return r;
    endfunction

endpackage

// ===== src/spk_front.sv =====
// Front end: configuration registers, input acceptance and the counter.
`timescale 1ns / 1ps

module spk_front import spk_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,
    input  logic                 s_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 q_full,
    output logic                 q_push,
    output blk_t                 q_data,
    output key_t                 key
);

    key_t        key_reg;
    key_t        key_next;
    logic [63:0] counter_reg;
    logic [63:0] counter_next;
    logic [63:0] counter_inc;
    logic        cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign s_tready  = ~q_full;
    assign q_push    = s_tvalid & s_tready;
    assign counter_inc = counter_reg + 64'd1;
    assign key       = key_reg;

    always_comb begin
        if (s_tuser) begin
            q_data.y = counter_inc[WORD_W-1:0];
            q_data.x = counter_inc[63:WORD_W];
        end else begin
            q_data.y = s_tdata[WORD_W-1:0];
            q_data.x = s_tdata[63:WORD_W];
        end
    end

    always_comb begin
        key_next     = key_reg;
        counter_next = counter_reg;
        if (q_push && s_tuser) begin
            counter_next = counter_inc;
        end
        if (cfg_wr) begin
            case (cfg_idx_e'(cfg_index))
                CFG_KEY0: key_next.k0 = cfg_data;
                CFG_KEY1: key_next.k1 = cfg_data;
                CFG_KEY2: key_next.k2 = cfg_data;
                CFG_KEY3: key_next.k3 = cfg_data;
                CFG_SEED: counter_next = {{WORD_W{1'b0}}, cfg_data};
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg     <= '{k3: KEY3_RESET, k2: KEY2_RESET, k1: KEY1_RESET, k0: KEY0_RESET};
            counter_reg <= {{WORD_W{1'b0}}, SEED_RESET};
        end else begin
            key_reg     <= key_next;
            counter_reg <= counter_next;
        end
    end

endmodule

// ===== src/spk_queue.sv =====
// Small FIFO of blocks between the front end and the round pipeline.
`timescale 1ns / 1ps

module spk_queue import spk_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  blk_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output blk_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    blk_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/spk_rounds.sv =====
// Back end: one Speck round per stage, with the key schedule carried alongside.
`timescale 1ns / 1ps

module spk_rounds import spk_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    input  blk_t  in_data,
    input  key_t  key,
    output logic  in_pop,
    output logic  out_valid,
    input  logic  out_ready,
    output blk_t  out_data
);

    // Per-stage state: block, current round key and the three schedule words
    // in the order they will be consumed.
    logic  valid_reg [ROUNDS];
    blk_t  blk_reg   [ROUNDS];
    word_t rk_reg    [ROUNDS];
    word_t la_reg    [ROUNDS];
    word_t lb_reg    [ROUNDS];
    word_t lc_reg    [ROUNDS];
    logic  advance;

    // The whole pipeline moves together; it holds only when the last stage
    // has a result that is not being taken.
    assign advance   = ~valid_reg[ROUNDS-1] | out_ready;
    assign in_pop    = in_valid & advance;
    assign out_valid = valid_reg[ROUNDS-1];
    assign out_data  = blk_reg[ROUNDS-1];

    for (genvar i = 0; i < ROUNDS; i++) begin : g_stage
        logic  v_in;
        blk_t  b_in;
        word_t rk_in;
        word_t la_in;
        word_t lb_in;
        word_t lc_in;
        blk_t  b_out;
        blk_t  k_out;

        if (i == 0) begin : g_first
            assign v_in  = in_valid;
            assign b_in  = in_data;
            assign rk_in = key.k0;
            assign la_in = key.k1;
            assign lb_in = key.k2;
            assign lc_in = key.k3;
        end else begin : g_next
            assign v_in  = valid_reg[i-1];
            assign b_in  = blk_reg[i-1];
            assign rk_in = rk_reg[i-1];
            assign la_in = la_reg[i-1];
            assign lb_in = lb_reg[i-1];
            assign lc_in = lc_reg[i-1];
        end

        assign b_out = round_mix(b_in, rk_in);
        // Key schedule step: x is the schedule word, y the round key,
        // and the round index is the key.
        assign k_out = round_mix('{x: la_in, y: rk_in}, WORD_W'(i));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (advance) begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                blk_reg[i] <= b_out;
                rk_reg[i]  <= k_out.y;
                la_reg[i]  <= lb_in;
                lb_reg[i]  <= lc_in;
                lc_reg[i]  <= k_out.x;
            end
        end
    end

endmodule

// ===== src/speck64_128_block_cipher_core.sv =====
// Speck 64/128 encryption core: top level joining front end, queue and round pipeline.
// Path: an input transfer is written into the queue, then passes the 27 round stages to m_tvalid.
// Throughput: one item per cycle unless m_tready stalls the 27-stage round pipeline (one round
// per stage, key schedule computed beside it); otherwise it accepts a new block every cycle.
// Reset: keys return to their default words, the counter to zero, the queue
// and the pipeline empty; there is no clearing pass.
`timescale 1ns / 1ps

module speck64_128_block_cipher_core import spk_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // [31:0] plain_low, [63:32] plain_high
    input  logic                 s_tuser,   // [0] cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // [31:0] cipher_low, [63:32] cipher_high
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic q_full;
    logic q_push;
    blk_t q_in;
    logic q_pop;
    logic q_valid;
    blk_t q_head;
    key_t key;
    blk_t res;

    spk_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in),
        .key       (key)
    );

    spk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    spk_rounds u_rounds (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_data   (q_head),
        .key       (key),
        .in_pop    (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {res.x, res.y};

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the Speck 64/128 block cipher core with counter mode.
`timescale 1ns / 1ps

module testbench;
    import spk_pkg::*;

    localparam logic CMD_BLOCK   = 1'b0;
    localparam logic CMD_COUNTER = 1'b1;

    // Indexes the register map leaves unassigned; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int CHUNKS         = 9;
    localparam int CHUNK_ITEMS    = 100;
    localparam word_t ALL_ONES    = 32'hffff_ffff;

    class keystream_scoreboard;
        word_t       key_words[4];
        logic [63:0] ctr_value;
        blk_t        cipher_q[$];
        int unsigned fail_count;

        function new();
            key_words[0] = KEY0_RESET;
            key_words[1] = KEY1_RESET;
            key_words[2] = KEY2_RESET;
            key_words[3] = KEY3_RESET;
            ctr_value    = {32'h0, SEED_RESET};
            fail_count   = 0;
        endfunction

        function void apply_write(input logic [CFG_IDX_W-1:0] idx, input word_t val);
            case (idx)
                CFG_KEY0: key_words[0] = val;
                CFG_KEY1: key_words[1] = val;
                CFG_KEY2: key_words[2] = val;
                CFG_KEY3: key_words[3] = val;
                CFG_SEED: ctr_value = {32'h0, val};
                default: ;
            endcase
        endfunction

        function void mix(inout word_t x, inout word_t y, input word_t k);
            x = (((x >> 8) | (x << 24)) + y) ^ k;
            y = ((y << 3) | (y >> 29)) ^ x;
        endfunction

        // The round keys are produced by the same mixing step, keyed by the round number.
        function blk_t encrypt_block(input word_t y, input word_t x);
            word_t rk;
            word_t sched[3];
            blk_t  r;
            rk = key_words[0];
            sched[0] = key_words[1];
            sched[1] = key_words[2];
            sched[2] = key_words[3];
            for (int i = 0; i < ROUNDS; i++) begin
                mix(x, y, rk);
                if (i + 1 < ROUNDS) begin
                    mix(sched[i % 3], rk, word_t'(i));
                end
            end
            r.x = x;
            r.y = y;
            return r;
        endfunction

        function void note_input(input logic cmd, input word_t lo, input word_t hi);
            if (cmd == CMD_COUNTER) begin
                ctr_value = ctr_value + 64'd1;
                cipher_q.push_back(encrypt_block(ctr_value[31:0], ctr_value[63:32]));
            end else begin
                cipher_q.push_back(encrypt_block(lo, hi));
            end
        endfunction

        function void check_output(input logic [63:0] data);
            blk_t got;
            blk_t want;
            got = data;
            if (cipher_q.size() == 0) begin
                $error("result %h arrived with nothing outstanding", data);
                fail_count++;
                return;
            end
            want = cipher_q.pop_front();
            if (got.y !== want.y) begin
                $error("cipher_low: expected %h, actual %h", want.y, got.y);
                fail_count++;
            end
            if (got.x !== want.x) begin
                $error("cipher_high: expected %h, actual %h", want.x, got.x);
                fail_count++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    keystream_scoreboard sb = new();

    int unsigned send_idle_pct = 11;
    int unsigned recv_idle_pct = 77;
    int unsigned hold_token    = 0;

    speck64_128_block_cipher_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_output(m_tdata);
        end
    end

    // Result side: random back-pressure, plus a long hold-off whenever one is requested.
    initial begin
        int unsigned hold_left;
        int unsigned tokens_seen;
        hold_left   = 0;
        tokens_seen = 0;
        m_tready    = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_token != tokens_seen) begin
                tokens_seen = hold_token;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #200000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic word_t pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic cmd, input word_t lo, input word_t hi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {hi, lo};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, lo, hi);
        @(negedge aclk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.apply_write(idx, val);
        @(negedge aclk);
    endtask

    task automatic configure(input word_t k0, input word_t k1, input word_t k2,
                             input word_t k3, input word_t seed);
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_SEED, seed);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every outstanding result has been checked and the core has gone quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.cipher_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_BLOCK;
        cfg_valid = 1'b0;
        cfg_index = CFG_KEY0;
        cfg_data  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part with the default key, then the counter carry and key extremes.
        send_item(CMD_BLOCK, 32'h0, 32'h0);
        send_item(CMD_BLOCK, ALL_ONES, ALL_ONES);
        send_item(CMD_BLOCK, ALL_ONES, 32'h0);
        send_item(CMD_BLOCK, 32'h0, ALL_ONES);
        send_item(CMD_BLOCK, 32'h7475_432d, 32'h3b72_6574);
        send_item(CMD_BLOCK, 32'haaaa_aaaa, 32'h5555_5555);
        send_item(CMD_BLOCK, 32'h5555_5555, 32'haaaa_aaaa);
        send_item(CMD_COUNTER, ALL_ONES, ALL_ONES);
        send_item(CMD_COUNTER, 32'h0, 32'h0);
        send_item(CMD_BLOCK, $urandom, $urandom);
        send_item(CMD_COUNTER, $urandom, $urandom);
        drain();

        // A seed of all ones makes the first increment carry into the high word.
        write_reg(CFG_SEED, ALL_ONES);
        cfg_valid <= 1'b0;
        send_item(CMD_COUNTER, 32'h0, 32'h0);
        send_item(CMD_COUNTER, 32'h0, 32'h0);
        send_item(CMD_BLOCK, 32'h1, 32'h0);
        send_item(CMD_COUNTER, 32'h0, 32'h0);
        drain();

        configure('0, '0, '0, '0, ALL_ONES - 1);
        send_item(CMD_BLOCK, 32'h0, 32'h0);
        send_item(CMD_COUNTER, 32'h0, 32'h0);
        drain();

        configure(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 32'h0);
        send_item(CMD_BLOCK, ALL_ONES, ALL_ONES);
        send_item(CMD_COUNTER, 32'h0, 32'h0);
        drain();

        for (int idx = CFG_UNMAPPED_LO; idx <= CFG_UNMAPPED_HI; idx++) begin
            write_reg(idx[CFG_IDX_W-1:0], $urandom);
        end
        cfg_valid <= 1'b0;
        send_item(CMD_COUNTER, 32'h0, 32'h0);
        send_item(CMD_BLOCK, $urandom, $urandom);
        drain();

        // Random part: three pacing phases of three chunks, new settings per chunk.
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            case (chunk / 3)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 77;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (chunk)
                0: configure(KEY0_RESET, KEY1_RESET, KEY2_RESET, KEY3_RESET, $urandom);
                1: configure('0, '0, '0, '0, ALL_ONES - $urandom_range(40));
                2: configure(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, '0);
                default: begin
                    configure($urandom, $urandom, $urandom, $urandom,
                              (chunk % 2) ? ALL_ONES - $urandom_range(40) : $urandom);
                end
            endcase
            if (chunk == 4 || chunk == 7) begin
                hold_token++;
            end
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
                send_item(1'($urandom_range(1)), pick_word(), pick_word());
            end
            drain();
        end

        if (sb.fail_count == 0 && sb.cipher_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/spk_pkg.sv
src/spk_front.sv
src/spk_queue.sv
src/spk_rounds.sv
src/speck64_128_block_cipher_core.sv
tb/sv/testbench.sv
